>>> design/bptc_pkg.sv
// Shared types and constants for the barometric compensation unit.
// Depends on nothing; every other design file imports this package.
`default_nettype none

package bptc_pkg;

    // Queue geometry between the front and back parts and at the result side.
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);
    localparam int RQ_DEPTH = 16;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // Compensation constants from the sensor datasheet.
    localparam int TEMP_BASE = 2000;
    localparam int TEMP_LO   = -4000;
    localparam int TEMP_HI   = 8500;
    localparam int PRES_LO   = 1000;
    localparam int PRES_HI   = 120000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SENS      = 3'd0,
        REG_OFF       = 3'd1,
        REG_SENS_TC   = 3'd2,
        REG_OFF_TC    = 3'd3,
        REG_REF_TEMP  = 3'd4,
        REG_TEMP_SLOPE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [16:0]        pressure_centi_mbar;
        logic               out_of_range;
    } t_result;

    typedef struct packed {
        logic [15:0] sens_coef;
        logic [15:0] off_coef;
        logic [15:0] sens_tc_coef;
        logic [15:0] off_tc_coef;
        logic [15:0] ref_temp_coef;
        logic [15:0] temp_slope_coef;
    } t_coefs;

    // Item as it leaves the front part: raw pressure plus the temperature delta.
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [24:0] dt;
    } t_front_item;

    // Occupancy seen by the top level for checking.
    typedef struct packed {
        logic [RQ_AW:0] credit;
        logic [RQ_AW:0] rq_level;
    } t_back_status;

endpackage

`default_nettype wire

>>> design/bptc_front.sv
// Front part of the compensation unit: input register and temperature delta.
// Depends on bptc_pkg.
`default_nettype none

module bptc_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    output logic                   o_full,
    input  bptc_pkg::t_in_item     i_item,
    input  bptc_pkg::t_coefs       i_coefs,
    input  wire                    i_q_full,
    output logic                   o_valid,
    output bptc_pkg::t_front_item  o_item
);
    import bptc_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_front_item r_item;
    t_front_item n_item;
    logic        w_accept;

    // The held item moves on whenever the queue has room.
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_valid   = w_accept || (r_valid && i_q_full);
        n_item    = r_item;
        if (w_accept) begin
            n_item.d1 = i_item.raw_pressure;
            n_item.dt = $signed({1'b0, i_item.raw_temperature})
                      - $signed({1'b0, i_coefs.ref_temp_coef, 8'h00});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

>>> design/bptc_mid_queue.sv
// Short queue that decouples the front part from the arithmetic back part.
// Depends on bptc_pkg.
`default_nettype none

module bptc_mid_queue (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push,
    input  bptc_pkg::t_front_item          i_data,
    output logic                           o_full,
    input  wire                            i_pop,
    output logic                           o_empty,
    output bptc_pkg::t_front_item          o_data,
    output logic [bptc_pkg::MQ_AW:0]       o_level
);
    import bptc_pkg::*;

    t_front_item        r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0]   r_wptr;
    logic [MQ_AW-1:0]   r_rptr;
    logic [MQ_AW:0]     r_level;
    logic [MQ_AW:0]     n_level;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_level == (MQ_AW+1)'(MQ_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_level;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_level = r_level + {{MQ_AW{1'b0}}, w_wr} - {{MQ_AW{1'b0}}, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_level <= n_level;
        end
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> design/bptc_back.sv
// Back part: seven-stage compensation pipeline, credit control and result queue.
// Depends on bptc_pkg.
`default_nettype none

module bptc_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  bptc_pkg::t_front_item      i_item,
    output logic                       o_take,
    input  bptc_pkg::t_coefs           i_coefs,
    output logic                       o_empty,
    output bptc_pkg::t_result          o_result,
    input  wire                        i_pop,
    output bptc_pkg::t_back_status     o_status
);
    import bptc_pkg::*;

    // Credit covers items in flight plus entries waiting in the result queue,
    // so the pipeline never has to stall.
    logic [RQ_AW:0]   r_credit;
    logic [RQ_AW:0]   n_credit;
    logic             w_issue;
    logic             w_pop_ok;
    logic [6:0]       r_vld;

    // Stage 1: the three products against the temperature delta.
    logic [23:0]        r1_d1;
    logic signed [24:0] r1_dt;
    logic signed [41:0] r1_pt;
    logic signed [41:0] r1_po;
    logic signed [41:0] r1_ps;

    // Stage 2: first-order temperature, offset and sensitivity.
    logic [23:0]        r2_d1;
    logic signed [24:0] r2_dt;
    logic signed [18:0] r2_d;
    logic [19:0]        r2_temp;
    logic [36:0]        r2_off;
    logic [35:0]        r2_sens;
    logic               r2_cold;
    logic [19:0]        w2_temp;
    logic [36:0]        w2_off;
    logic [35:0]        w2_sens;

    // Stage 3: squares for the second-order terms.
    logic [23:0]        r3_d1;
    logic [19:0]        r3_temp;
    logic [36:0]        r3_off;
    logic [35:0]        r3_sens;
    logic               r3_cold;
    logic [35:0]        r3_sq;
    logic [48:0]        r3_dtsq;
    logic signed [37:0] w3_sq;
    logic signed [49:0] w3_dtsq;

    // Stage 4: second-order corrections applied.
    logic [23:0]        r4_d1;
    logic [20:0]        r4_temp;
    logic [38:0]        r4_off;
    logic [37:0]        r4_sens;
    logic [17:0]        w4_t2;
    logic [37:0]        w4_sq5;
    logic [36:0]        w4_off2;
    logic [35:0]        w4_sens2;

    // Stage 5: partial products of raw pressure times sensitivity.
    logic [20:0]        r5_temp;
    logic [38:0]        r5_off;
    logic [42:0]        r5_lo;
    logic signed [43:0] r5_hi;

    // Stage 6: product summed and scaled.
    logic [20:0]        r6_temp;
    logic [38:0]        r6_off;
    logic [42:0]        r6_ps;
    logic [63:0]        w6_prod;

    // Stage 7: pressure before clamping.
    logic signed [20:0] r7_temp;
    logic signed [28:0] r7_pres;
    logic [43:0]        w7_diff;

    // Clamp and result queue.
    t_result            w_res;
    logic               w_t_lo;
    logic               w_t_hi;
    logic               w_p_lo;
    logic               w_p_hi;
    t_result            r_rq [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wptr;
    logic [RQ_AW-1:0]   r_rptr;
    logic [RQ_AW:0]     r_level;
    logic [RQ_AW:0]     n_level;

    assign w_issue  = i_valid && (r_credit < (RQ_AW+1)'(RQ_DEPTH));
    assign o_take   = w_issue;
    assign o_empty  = (r_level == '0);
    assign w_pop_ok = i_pop && !o_empty;
    assign o_result = r_rq[r_rptr];
    assign o_status = '{credit: r_credit, rq_level: r_level};

    always_comb begin
        n_credit = r_credit + {{RQ_AW{1'b0}}, w_issue} - {{RQ_AW{1'b0}}, w_pop_ok};
        n_level  = r_level + {{RQ_AW{1'b0}}, r_vld[6]} - {{RQ_AW{1'b0}}, w_pop_ok};
    end

    // Arithmetic shifts are taken as bit slices of sign-extended values, which
    // rounds toward minus infinity.
    always_comb begin
        w2_temp = {r1_pt[41], r1_pt[41:23]} + 20'(TEMP_BASE);
        w2_off  = {{2{r1_po[41]}}, r1_po[41:7]} + {5'b0, i_coefs.off_coef, 16'h0000};
        w2_sens = {{2{r1_ps[41]}}, r1_ps[41:8]} + {5'b0, i_coefs.sens_coef, 15'h0000};
    end

    always_comb begin
        w3_sq   = r2_d * r2_d;
        w3_dtsq = r2_dt * r2_dt;
    end

    always_comb begin
        w4_sq5 = {r3_sq, 2'b00} + {2'b00, r3_sq};
        if (r3_cold) begin
            w4_t2    = r3_dtsq[48:31];
            w4_off2  = w4_sq5[37:1];
            w4_sens2 = w4_sq5[37:2];
        end else begin
            w4_t2    = '0;
            w4_off2  = '0;
            w4_sens2 = '0;
        end
    end

    always_comb begin
        w6_prod = {r5_hi[43], r5_hi, 19'h00000} + {21'h000000, r5_lo};
        w7_diff = {r6_ps[42], r6_ps} - {{5{r6_off[38]}}, r6_off};
    end

    always_comb begin
        w_t_lo = (r7_temp < 21'sd0 + 21'(TEMP_LO)) && r7_temp[20];
        w_t_hi = (r7_temp > 21'sd8500);
        w_p_lo = (r7_pres < 29'sd1000);
        w_p_hi = (r7_pres > 29'sd120000);
        w_res.temperature_centi   = r7_temp[14:0];
        w_res.pressure_centi_mbar = r7_pres[16:0];
        if (w_t_lo) begin
            w_res.temperature_centi = 15'(TEMP_LO);
        end
        if (w_t_hi) begin
            w_res.temperature_centi = 15'(TEMP_HI);
        end
        if (w_p_lo) begin
            w_res.pressure_centi_mbar = 17'(PRES_LO);
        end
        if (w_p_hi) begin
            w_res.pressure_centi_mbar = 17'(PRES_HI);
        end
        w_res.out_of_range = w_t_lo || w_t_hi || w_p_lo || w_p_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_vld    <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_level  <= '0;
        end else begin
            r_credit <= n_credit;
            r_vld    <= {r_vld[5:0], w_issue};
            if (r_vld[6]) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_level <= n_level;
        end

        r1_d1 <= i_item.d1;
        r1_dt <= i_item.dt;
        r1_pt <= i_item.dt * $signed({1'b0, i_coefs.temp_slope_coef});
        r1_po <= $signed({1'b0, i_coefs.off_tc_coef}) * i_item.dt;
        r1_ps <= $signed({1'b0, i_coefs.sens_tc_coef}) * i_item.dt;

        r2_d1   <= r1_d1;
        r2_dt   <= r1_dt;
        r2_d    <= r1_pt[41:23];
        r2_temp <= w2_temp;
        r2_off  <= w2_off;
        r2_sens <= w2_sens;
        r2_cold <= r1_pt[41];

        r3_d1   <= r2_d1;
        r3_temp <= r2_temp;
        r3_off  <= r2_off;
        r3_sens <= r2_sens;
        r3_cold <= r2_cold;
        r3_sq   <= w3_sq[35:0];
        r3_dtsq <= w3_dtsq[48:0];

        r4_d1   <= r3_d1;
        r4_temp <= {r3_temp[19], r3_temp} - {3'b000, w4_t2};
        r4_off  <= {{2{r3_off[36]}}, r3_off} - {2'b00, w4_off2};
        r4_sens <= {{2{r3_sens[35]}}, r3_sens} - {2'b00, w4_sens2};

        r5_temp <= r4_temp;
        r5_off  <= r4_off;
        r5_lo   <= r4_d1 * r4_sens[18:0];
        r5_hi   <= $signed({1'b0, r4_d1}) * $signed(r4_sens[37:19]);

        r6_temp <= r5_temp;
        r6_off  <= r5_off;
        r6_ps   <= w6_prod[63:21];

        r7_temp <= r6_temp;
        r7_pres <= w7_diff[43:15];

        if (r_vld[6]) begin
            r_rq[r_wptr] <= w_res;
        end
    end

endmodule

`default_nettype wire

>>> design/baro_pressure_temp_compensation_unit.sv
// Top level of the barometric pressure and temperature compensation unit.
// Depends on bptc_pkg, bptc_front, bptc_mid_queue and bptc_back.
//
// This block turns one raw pressure conversion (D1) and one raw temperature
// conversion (D2) into a compensated temperature in hundredths of a degree and
// a compensated pressure in hundredths of a millibar, using the six factory
// calibration words with the datasheet's second-order correction below 20.00
// degrees. Results beyond -40.00..85.00 degrees or 10.00..1200.00 mbar are
// saturated to the nearest bound and flagged with out_of_range. The block
// looks like a queue from both sides: a request is taken when push is high and
// full is low, and the oldest result is taken when pop is high and empty is
// low. It accepts one request per clock, sustained, for as long as results are
// popped. On its way, each result passes in turn through the input register
// of the front part, the four-entry queue between front and back, and the
// back part's seven-stage arithmetic pipeline, whose widest step is the
// 24-by-38-bit pressure product split into two partial products. The result
// queue holds sixteen entries, and the pipeline only takes work it has room
// for, so a stalled consumer backs up into full without losing anything.
// Calibration words are written through the write port at register indexes
// 0 (C1) to 5 (C6); other indexes are ignored, and all words reset to zero.
// Write them only while no request is in flight.
`default_nettype none

module baro_pressure_temp_compensation_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  bptc_pkg::t_in_item   i_in_item,
    output logic                 empty,
    input  wire                  pop,
    output bptc_pkg::t_result    o_result,
    input  wire                  i_cfg_wr_en,
    input  wire [2:0]            i_cfg_index,
    input  wire [15:0]           i_cfg_wdata
);
    import bptc_pkg::*;

    // Calibration words, held as one struct so each part sees the whole set.
    t_coefs        r_coefs;

    logic          w_front_valid;
    t_front_item   w_front_item;
    logic          w_mq_full;
    logic          w_mq_empty;
    t_front_item   w_mq_item;
    logic [MQ_AW:0] w_mq_level;
    logic          w_take;
    t_back_status  w_bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SENS:       r_coefs.sens_coef       <= i_cfg_wdata;
                REG_OFF:        r_coefs.off_coef        <= i_cfg_wdata;
                REG_SENS_TC:    r_coefs.sens_tc_coef    <= i_cfg_wdata;
                REG_OFF_TC:     r_coefs.off_tc_coef     <= i_cfg_wdata;
                REG_REF_TEMP:   r_coefs.ref_temp_coef   <= i_cfg_wdata;
                REG_TEMP_SLOPE: r_coefs.temp_slope_coef <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The front registers the request and forms the temperature delta.
    bptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_in_item),
        .i_coefs  (r_coefs),
        .i_q_full (w_mq_full),
        .o_valid  (w_front_valid),
        .o_item   (w_front_item)
    );

    // The short queue lets the front keep taking requests while the back
    // waits for room in its result queue.
    bptc_mid_queue u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_item),
        .o_full  (w_mq_full),
        .i_pop   (w_take),
        .o_empty (w_mq_empty),
        .o_data  (w_mq_item),
        .o_level (w_mq_level)
    );

    // The back runs the arithmetic and holds finished results until popped.
    bptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_mq_empty),
        .i_item   (w_mq_item),
        .o_take   (w_take),
        .i_coefs  (r_coefs),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop),
        .o_status (w_bstat)
    );

    // Items in flight plus waiting results never exceed the result queue.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.credit <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("credit count exceeds result queue depth");

    // Every waiting result was counted against the credit when it was issued.
    a_credit_covers_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.rq_level <= w_bstat.credit)
        else $error("result queue holds more than was issued");

    // The middle queue never overfills.
    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mq_level <= (MQ_AW+1)'(MQ_DEPTH))
        else $error("middle queue level out of bounds");

    // Reset leaves the block empty and ready for a request.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("block not empty and ready after reset");

endmodule

`default_nettype wire

>>> tb/bptc_reading_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the barometric compensation unit: it mirrors the calibration
// writes, predicts every compensated reading and checks the result queue.
// Depends on bptc_pkg for the payload structs and the register index enum.
module bptc_reading_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire                i_full,
    input  bptc_pkg::t_in_item i_in_item,
    input  wire                i_empty,
    input  wire                i_pop,
    input  bptc_pkg::t_result  i_result,
    input  wire                i_cfg_wr_en,
    input  wire [2:0]          i_cfg_index,
    input  wire [15:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_cold,
    output int                 o_clamped
);
    import bptc_pkg::*;

    t_coefs  cal = '0;
    t_result expected_readings[$];
    int      fails = 0;
    int      checked = 0;
    int      cold_seen = 0;
    int      clamped_seen = 0;

    // Second-order compensation in 64-bit signed arithmetic; every shift of a
    // signed value rounds toward minus infinity, as the datasheet divisions do.
    function automatic t_result compensate_reading(input t_in_item item, input t_coefs c,
                                                   output bit cold);
        longint  d1;
        longint  dt;
        longint  temp;
        longint  off;
        longint  sens;
        longint  pres;
        longint  dev;
        longint  sq5;
        t_result r;
        d1   = longint'(item.raw_pressure);
        dt   = longint'(item.raw_temperature) - (longint'(c.ref_temp_coef) <<< 8);
        temp = TEMP_BASE + ((dt * longint'(c.temp_slope_coef)) >>> 23);
        off  = (longint'(c.off_coef) <<< 16) + ((longint'(c.off_tc_coef) * dt) >>> 7);
        sens = (longint'(c.sens_coef) <<< 15) + ((longint'(c.sens_tc_coef) * dt) >>> 8);
        cold = (temp < TEMP_BASE);
        if (cold) begin
            dev  = temp - TEMP_BASE;
            sq5  = 5 * dev * dev;
            temp = temp - ((dt * dt) >>> 31);
            off  = off - (sq5 >>> 1);
            sens = sens - (sq5 >>> 2);
        end
        pres = (((d1 * sens) >>> 21) - off) >>> 15;
        r.out_of_range = 1'b0;
        if (temp < TEMP_LO) begin
            temp = TEMP_LO;
            r.out_of_range = 1'b1;
        end
        if (temp > TEMP_HI) begin
            temp = TEMP_HI;
            r.out_of_range = 1'b1;
        end
        if (pres < PRES_LO) begin
            pres = PRES_LO;
            r.out_of_range = 1'b1;
        end
        if (pres > PRES_HI) begin
            pres = PRES_HI;
            r.out_of_range = 1'b1;
        end
        r.temperature_centi   = temp[14:0];
        r.pressure_centi_mbar = pres[16:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        bit      cold;
        if (!i_rst_n) begin
            cal = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_SENS:       cal.sens_coef       = i_cfg_wdata;
                    REG_OFF:        cal.off_coef        = i_cfg_wdata;
                    REG_SENS_TC:    cal.sens_tc_coef    = i_cfg_wdata;
                    REG_OFF_TC:     cal.off_tc_coef     = i_cfg_wdata;
                    REG_REF_TEMP:   cal.ref_temp_coef   = i_cfg_wdata;
                    REG_TEMP_SLOPE: cal.temp_slope_coef = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Results are retired before the new request is queued, so a result
            // can never be matched against the request taken at the same edge.
            if (i_pop && !i_empty) begin
                got = i_result;
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d / %0d / %0b",
                             $time, got.temperature_centi, got.pressure_centi_mbar,
                             got.out_of_range);
                    fails++;
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (got.temperature_centi !== want.temperature_centi) begin
                        $display("%0t: temperature_centi expected %0d, got %0d",
                                 $time, want.temperature_centi, got.temperature_centi);
                        fails++;
                    end
                    if (got.pressure_centi_mbar !== want.pressure_centi_mbar) begin
                        $display("%0t: pressure_centi_mbar expected %0d, got %0d",
                                 $time, want.pressure_centi_mbar, got.pressure_centi_mbar);
                        fails++;
                    end
                    if (got.out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range expected %0b, got %0b",
                                 $time, want.out_of_range, got.out_of_range);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full) begin
                want = compensate_reading(i_in_item, cal, cold);
                expected_readings.push_back(want);
                if (cold)
                    cold_seen++;
                if (want.out_of_range)
                    clamped_seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_readings.size();
        o_checked    <= checked;
        o_cold       <= cold_seen;
        o_clamped    <= clamped_seen;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the compensation unit testbench: clock, reset, calibration writes,
// request and pop stimulus, and the verdict. Depends on bptc_pkg, the unit
// itself and bptc_reading_checker, which does all prediction and comparison.
module tb;
    import bptc_pkg::*;

    // Register indexes beyond the six calibration words; writes to them must
    // leave every word untouched.
    localparam logic [2:0] SPARE_IDX_LO = 3'd6;
    localparam logic [2:0] SPARE_IDX_HI = 3'd7;

    localparam int NUM_SETS      = 10;
    localparam int ITEMS_PER_SET = 210;
    localparam int ZERO_SET      = 2;
    localparam int ZERO_SET_ITEMS = 40;

    // Datasheet example calibration, used as the nominal sensor.
    localparam t_coefs TYPICAL_CAL = '{sens_coef: 16'd40127, off_coef: 16'd36924,
                                       sens_tc_coef: 16'd23317, off_tc_coef: 16'd23282,
                                       ref_temp_coef: 16'd33464, temp_slope_coef: 16'd28312};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    t_in_item    in_item = '0;
    logic        full;
    logic        empty;
    t_result     result;

    int fail_count;
    int pending_count;
    int checked_count;
    int cold_count;
    int clamped_count;

    // Idling knobs: stall_pct sets how often the pop side stalls, and calm_run,
    // shared by both sides, makes both sides run flat out in the closing set.
    int stall_pct = 10;
    bit calm_run = 1'b0;
    int sets_loaded = 0;

    baro_pressure_temp_compensation_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    bptc_reading_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_cold       (cold_count),
        .o_clamped    (clamped_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop. The slowest correct run, with every request hit by the
    // longest request gap and every result by the longest pop stall, stays
    // well below this.
    initial begin
        #5_000_000;
        $display("Timeout: results still outstanding");
        $display("Some tests failed");
        $finish;
    end

    // Pop side: random stall bursts; how often a burst starts depends on the
    // current set, and heavy settings back the result queue up far enough that
    // full is raised toward the request side.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (!calm_run && $urandom_range(0, 99) < stall_pct) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Hands one request to the unit and returns at the edge that accepted it.
    // Outside the closing set a random gap may follow.
    task automatic send_reading(input t_in_item item);
        push    <= 1'b1;
        in_item <= item;
        do @(posedge i_clk); while (full);
        if (!calm_run && $urandom_range(0, 99) < 12) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Stops requesting and waits until every predicted reading has been popped.
    // The checker's count is registered, so the task waits for a clock edge before it first reads it.
    task automatic wait_for_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_word(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Loads all six calibration words, with junk written to the spare indexes
    // in between; the unit is idle whenever this is called.
    task automatic load_calibration(input t_coefs cal);
        write_word(REG_SENS, cal.sens_coef);
        write_word(REG_OFF, cal.off_coef);
        write_word(SPARE_IDX_LO, 16'($urandom));
        write_word(REG_SENS_TC, cal.sens_tc_coef);
        write_word(REG_OFF_TC, cal.off_tc_coef);
        write_word(SPARE_IDX_HI, 16'($urandom));
        write_word(REG_REF_TEMP, cal.ref_temp_coef);
        write_word(REG_TEMP_SLOPE, cal.temp_slope_coef);
        cfg_wr_en <= 1'b0;
        sets_loaded++;
    endtask

    // A tame word stays near the nominal sensor; a wild one is often pinned to
    // zero or to all ones.
    function automatic logic [15:0] calib_word(input logic [15:0] nominal, input bit wild);
        int roll;
        roll = $urandom_range(0, 9);
        if (!wild)
            return nominal + 16'($urandom_range(0, 2000)) - 16'd1000;
        if (roll < 2)
            return 16'h0000;
        if (roll < 4)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Most random requests are aimed at plausible readings: the raw temperature
    // lands within roughly -55 to 95 degrees and, for most of these, the raw
    // pressure is chosen for a target pressure from nothing up to just past the
    // top of the range, so clamps, cold correction and normal path are all well
    // visited. The rest use a random raw pressure or fully random raw words.
    function automatic t_in_item pick_reading(input t_coefs cal);
        t_in_item item;
        longint   span;
        longint   d2;
        longint   dt;
        longint   sens_est;
        longint   off_est;
        longint   d1;
        int       kind;
        kind = $urandom_range(0, 99);
        item.raw_pressure    = 24'($urandom);
        item.raw_temperature = 24'($urandom);
        if (kind < 15)
            return item;
        if (cal.temp_slope_coef != 0)
            span = (longint'(7500) <<< 23) / longint'(cal.temp_slope_coef);
        else
            span = longint'(1) <<< 23;
        if (span > (longint'(1) <<< 24))
            span = longint'(1) <<< 24;
        d2 = (longint'(cal.ref_temp_coef) <<< 8) + longint'($urandom_range(0, 2 * span)) - span;
        if (d2 < 0)
            d2 = 0;
        if (d2 > 64'hFF_FFFF)
            d2 = 64'hFF_FFFF;
        item.raw_temperature = d2[23:0];
        if (kind < 75) begin
            dt       = d2 - (longint'(cal.ref_temp_coef) <<< 8);
            sens_est = (longint'(cal.sens_coef) <<< 15)
                       + ((longint'(cal.sens_tc_coef) * dt) >>> 8);
            off_est  = (longint'(cal.off_coef) <<< 16)
                       + ((longint'(cal.off_tc_coef) * dt) >>> 7);
            if (sens_est > 0) begin
                d1 = (((longint'($urandom_range(0, 125000)) <<< 15) + off_est) <<< 21)
                     / sens_est;
                if (d1 < 0)
                    d1 = 0;
                if (d1 > 64'hFF_FFFF)
                    d1 = 64'hFF_FFFF;
                item.raw_pressure = d1[23:0];
            end
        end
        return item;
    endfunction

    initial begin : stimulus
        t_coefs cal;
        int     set_no;
        int     count;
        int     k;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests. With the words still at their reset value of zero
        // the pressure collapses to nothing and must clamp low.
        send_reading('{24'd0, 24'd0});
        send_reading('{24'hFFFFFF, 24'hFFFFFF});

        wait_for_results();
        load_calibration(TYPICAL_CAL);
        // Datasheet example reading, then the 20.00 degree boundary: exactly
        // at the reference temperature, and one raw count below it, where the
        // second-order correction first applies.
        send_reading('{24'd9085466, 24'd8569150});
        send_reading('{24'd9085466, 24'd8566784});
        send_reading('{24'd9085466, 24'd8566783});
        // Around -10, -20 and -25 degrees; the extra terms meant for readings
        // below -15 degrees are not part of the unit.
        send_reading('{24'd9085466, 24'd7677884});
        send_reading('{24'd9085466, 24'd7381584});
        send_reading('{24'd9085466, 24'd7233484});
        // Temperature driven past both ends of its range.
        send_reading('{24'd9085466, 24'd0});
        send_reading('{24'd9085466, 24'hFFFFFF});
        // Pressure driven past both ends of its range.
        send_reading('{24'd0, 24'd8569150});
        send_reading('{24'hFFFFFF, 24'd8569150});
        // Alternating bit patterns on both raw words.
        send_reading('{24'hAAAAAA, 24'h555555});
        send_reading('{24'h555555, 24'hAAAAAA});

        // Every word at its maximum: the widest products the unit can see.
        wait_for_results();
        load_calibration('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_reading('{24'd0, 24'd0});
        send_reading('{24'hFFFFFF, 24'hFFFFFF});
        send_reading('{24'h800000, 24'hFF0000});

        // Random sets. The first three are the nominal sensor, all ones and
        // all zeros; after that, tame sets near the nominal sensor alternate
        // with wild ones full of extreme words.
        for (set_no = 0; set_no < NUM_SETS; set_no++) begin
            case (set_no)
                0:        cal = TYPICAL_CAL;
                1:        cal = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                ZERO_SET: cal = '0;
                default: begin
                    cal.sens_coef       = calib_word(TYPICAL_CAL.sens_coef, set_no[0] == 0);
                    cal.off_coef        = calib_word(TYPICAL_CAL.off_coef, set_no[0] == 0);
                    cal.sens_tc_coef    = calib_word(TYPICAL_CAL.sens_tc_coef, set_no[0] == 0);
                    cal.off_tc_coef     = calib_word(TYPICAL_CAL.off_tc_coef, set_no[0] == 0);
                    cal.ref_temp_coef   = calib_word(TYPICAL_CAL.ref_temp_coef, set_no[0] == 0);
                    cal.temp_slope_coef = calib_word(TYPICAL_CAL.temp_slope_coef,
                                                     set_no[0] == 0);
                end
            endcase
            wait_for_results();
            load_calibration(cal);
            calm_run  = (set_no == NUM_SETS - 1);
            stall_pct = (set_no % 3 == 1) ? 45 : 10;
            count     = (set_no == ZERO_SET) ? ZERO_SET_ITEMS : ITEMS_PER_SET;
            for (k = 0; k < count; k++) begin
                send_reading(pick_reading(cal));
                // Once mid-set the requests hold off until the unit has
                // handed back everything, then resume from an empty pipeline.
                if (set_no == 3 && k == count / 2)
                    wait_for_results();
            end
        end

        // Let everything drain, then keep clocking with no requests so that any
        // stray result would still be caught.
        wait_for_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d calibration sets and %0d compensated readings:",
                 sets_loaded, checked_count);
        $display("%0d took the below-20-degree correction and %0d were saturated.",
                 cold_count, clamped_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> baro_pressure_temp_compensation_unit.f
design/bptc_pkg.sv
design/bptc_front.sv
design/bptc_mid_queue.sv
design/bptc_back.sv
design/baro_pressure_temp_compensation_unit.sv
tb/bptc_reading_checker.sv
tb/tb.sv
